/* hw/rtl/multi_source_tick_scheduler_defines.svh */
// Assertion macros for the tick scheduler.
// Each macro expects clk and rst_n to be in scope.
`ifndef MULTI_SOURCE_TICK_SCHEDULER_DEFINES_SVH
`define MULTI_SOURCE_TICK_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MST_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mst assertion failed");
`define MST_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("mst forbidden condition");
`else
`define MST_ASSERT(label, prop)
`define MST_ASSERT_NEVER(label, expr)
`endif

`endif

/* hw/rtl/mst_pkg.sv */
package mst_pkg;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned MASK_W   = 5;
    localparam int unsigned SECS_W   = 16;
    localparam int unsigned SRC_W    = 6;
    localparam int unsigned PHASE_W  = 8;
    localparam int unsigned WAIT_W   = 24;
    localparam int unsigned TPS_W    = 8;
    localparam int unsigned PHASES   = 1 << PHASE_W;

    localparam logic [TPS_W-1:0] TPS_RESET = 8'd61;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WAIT   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 3'd4;

    localparam int unsigned MAIN_BIT = 5;

    localparam int unsigned DIV_THERM  = 128;
    localparam int unsigned DIV_VOLT   = 62;
    localparam int unsigned DIV_CONN   = 13;
    localparam int unsigned DIV_OUTPUT = 6;
    localparam int unsigned DIV_INPUT  = 3;

    // Bit p set when phase p is a multiple of div.
    function automatic logic [PHASES-1:0] mult_table(int unsigned div);
        logic [PHASES-1:0] t;
        t = '0;
        for (int unsigned k = 0; k < PHASES; k++)
        begin
            if (k * div < PHASES)
            begin
                t[PHASE_W'(k * div)] = 1'b1;
            end
        end
        return t;
    endfunction

    localparam logic [PHASES-1:0] MULT_THERM  = mult_table(DIV_THERM);
    localparam logic [PHASES-1:0] MULT_VOLT   = mult_table(DIV_VOLT);
    localparam logic [PHASES-1:0] MULT_CONN   = mult_table(DIV_CONN);
    localparam logic [PHASES-1:0] MULT_OUTPUT = mult_table(DIV_OUTPUT);
    localparam logic [PHASES-1:0] MULT_INPUT  = mult_table(DIV_INPUT);

    typedef struct packed {
        logic              wait_active;
        logic              therm_event;
        logic              adc_start;
        logic              conn_event;
        logic              output_event;
        logic              input_event;
        logic [SRC_W-1:0]  sources_now;
        logic              clock_running;
    } result_t;

endpackage

/* hw/rtl/mst_cmd_if.sv */
interface mst_cmd_if
    import mst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [MASK_W-1:0] source_mask;
    logic [SECS_W-1:0] wait_seconds;

    modport source (output valid, output func, output source_mask, output wait_seconds,
                    input ready);
    modport sink   (input valid, input func, input source_mask, input wait_seconds,
                    output ready);
endinterface

/* hw/rtl/mst_rsp_if.sv */
interface mst_rsp_if
    import mst_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             wait_active;
    logic             therm_event;
    logic             adc_start;
    logic             conn_event;
    logic             output_event;
    logic             input_event;
    logic [SRC_W-1:0] sources_now;
    logic             clock_running;

    modport source (output valid, output wait_active, output therm_event, output adc_start,
                    output conn_event, output output_event, output input_event,
                    output sources_now, output clock_running, input ready);
    modport sink   (input valid, input wait_active, input therm_event, input adc_start,
                    input conn_event, input output_event, input input_event,
                    input sources_now, input clock_running, output ready);
endinterface

/* hw/rtl/multi_source_tick_scheduler.sv */
// Multi-source tick scheduler.
// cmd: valid/ready channel carrying func, source_mask and wait_seconds.
//   func selects tick, start sources, stop sources, set wait or status.
// rsp: valid/ready channel; exactly one result per command transfer,
//   in command order, with the strobes, wait flag and active source mask.
// cfg_we/cfg_data: writes ticks_per_second; write only while idle.
// The result of a command is registered in the result register, or in the skid entry while rsp is stalled.
// Throughput: one command per cycle while cmd.ready is high; the state update (mask, phase,
//   countdown, 16x8 multiply for set wait) is combinational and is registered on the transfer.
// Stall: a result register plus one skid entry sit on rsp; cmd.ready
//   drops only once the skid entry is full, and returns as soon as the
//   receiver takes a result. Nothing is dropped or repeated.
// Reset (async, rst_n low): no source active, phase and countdown zero,
//   ticks_per_second back to 61, both output entries empty.
`include "multi_source_tick_scheduler_defines.svh"

module multi_source_tick_scheduler
    import mst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mst_cmd_if.sink           cmd,
    mst_rsp_if.source         rsp,
    input  logic              cfg_we,
    input  logic [TPS_W-1:0]  cfg_data
);

    logic [TPS_W-1:0]   tps_reg;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;

    result_t res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;
    logic    tick_counted;
    logic [WAIT_W-1:0]  wait_load;
    logic [WAIT_W-1:0]  wait_dec;

    assign cmd.ready = !skid_valid_reg;
    assign accept    = cmd.valid && cmd.ready;

    assign wait_load = WAIT_W'(cmd.wait_seconds) * WAIT_W'(tps_reg);
    assign wait_dec  = (wait_reg != '0) ? wait_reg - WAIT_W'(1) : wait_reg;

    always_comb
    begin
        src_next     = src_reg;
        phase_next   = phase_reg;
        wait_next    = wait_reg;
        tick_counted = 1'b0;
        unique case (cmd.func)
            FUNC_TICK:
            begin
                if (src_reg != '0)
                begin
                    tick_counted = 1'b1;
                    phase_next   = phase_reg + PHASE_W'(1);
                    if (src_reg[MAIN_BIT])
                    begin
                        wait_next = wait_dec;
                        if (wait_dec == '0)
                        begin
                            src_next[MAIN_BIT] = 1'b0;
                        end
                    end
                end
            end
            FUNC_START:
            begin
                src_next = src_reg | {1'b0, cmd.source_mask};
            end
            FUNC_STOP:
            begin
                src_next = src_reg & ~{1'b0, cmd.source_mask};
            end
            FUNC_WAIT:
            begin
                wait_next          = wait_load;
                src_next[MAIN_BIT] = (cmd.wait_seconds != '0);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.wait_active   = (wait_next != '0);
        res.therm_event   = tick_counted && src_next[0] && MULT_THERM[phase_next];
        res.adc_start     = tick_counted && src_next[1] && MULT_VOLT[phase_next];
        res.conn_event    = tick_counted && src_next[2] && MULT_CONN[phase_next];
        res.output_event  = tick_counted && src_next[3] && MULT_OUTPUT[phase_next];
        res.input_event   = tick_counted && src_next[4] && MULT_INPUT[phase_next];
        res.sources_now   = src_next;
        res.clock_running = (src_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg   <= TPS_RESET;
            src_reg   <= '0;
            phase_reg <= '0;
            wait_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tps_reg <= cfg_data;
            end
            if (accept)
            begin
                src_reg   <= src_next;
                phase_reg <= phase_next;
                wait_reg  <= wait_next;
            end
        end
    end

    // Result register with one skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (rsp.ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.ready || !out_valid_reg)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.wait_active   = out_reg.wait_active;
    assign rsp.therm_event   = out_reg.therm_event;
    assign rsp.adc_start     = out_reg.adc_start;
    assign rsp.conn_event    = out_reg.conn_event;
    assign rsp.output_event  = out_reg.output_event;
    assign rsp.input_event   = out_reg.input_event;
    assign rsp.sources_now   = out_reg.sources_now;
    assign rsp.clock_running = out_reg.clock_running;

    `MST_ASSERT_NEVER(a_skid_without_out, skid_valid_reg && !out_valid_reg)
    `MST_ASSERT(a_running_matches_mask,
        out_valid_reg |-> (out_reg.clock_running == (out_reg.sources_now != '0)))
    `MST_ASSERT(a_tick_advances_phase,
        (accept && cmd.func == FUNC_TICK && src_reg != '0) |=>
            (phase_reg == $past(phase_reg) + PHASE_W'(1)))
    `MST_ASSERT(a_idle_holds_state,
        !accept |=> ($stable(src_reg) && $stable(phase_reg) && $stable(wait_reg)))

endmodule

/* tb/sv/tick_schedule_checker.sv */
`timescale 1ns / 100ps

module tick_schedule_checker
    import mst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    mst_cmd_if               cmd,
    mst_rsp_if               rsp,
    input  logic             cfg_we,
    input  logic [TPS_W-1:0] cfg_data,
    output int unsigned      mismatches,
    output int unsigned      outstanding
);

    localparam int unsigned SRC_THERM  = 0;
    localparam int unsigned SRC_VOLT   = 1;
    localparam int unsigned SRC_CONN   = 2;
    localparam int unsigned SRC_OUTPUT = 3;
    localparam int unsigned SRC_INPUT  = 4;

    logic [SRC_W-1:0]   src_q;
    logic [PHASE_W-1:0] phase_q;
    logic [WAIT_W-1:0]  wait_q;
    logic [TPS_W-1:0]   tps_q;

    result_t results_due[$];

    task automatic schedule_step(input logic [FUNC_W-1:0] f, input logic [MASK_W-1:0] m,
                                 input logic [SECS_W-1:0] s, output result_t r);
        r = '0;
        case (f)
            FUNC_TICK:
            begin
                if (src_q != '0)
                begin
                    phase_q = phase_q + PHASE_W'(1);
                    if (src_q[MAIN_BIT])
                    begin
                        if (wait_q != '0)
                            wait_q = wait_q - WAIT_W'(1);
                        if (wait_q == '0)
                            src_q[MAIN_BIT] = 1'b0;
                    end
                    r.therm_event  = src_q[SRC_THERM]  && (32'(phase_q) % DIV_THERM == 0);
                    r.adc_start    = src_q[SRC_VOLT]   && (32'(phase_q) % DIV_VOLT == 0);
                    r.conn_event   = src_q[SRC_CONN]   && (32'(phase_q) % DIV_CONN == 0);
                    r.output_event = src_q[SRC_OUTPUT] && (32'(phase_q) % DIV_OUTPUT == 0);
                    r.input_event  = src_q[SRC_INPUT]  && (32'(phase_q) % DIV_INPUT == 0);
                end
            end
            FUNC_START:
                src_q = src_q | {1'b0, m};
            FUNC_STOP:
                src_q = src_q & ~{1'b0, m};
            FUNC_WAIT:
            begin
                wait_q = WAIT_W'(s) * WAIT_W'(tps_q);
                src_q[MAIN_BIT] = (s != '0);
            end
            default:
            begin
            end
        endcase
        r.wait_active   = (wait_q != '0);
        r.sources_now   = src_q;
        r.clock_running = (src_q != '0);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            src_q   = '0;
            phase_q = '0;
            wait_q  = '0;
            tps_q   = TPS_RESET;
            results_due.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                tps_q = cfg_data;
            if (rsp.valid && rsp.ready)
            begin
                got.wait_active   = rsp.wait_active;
                got.therm_event   = rsp.therm_event;
                got.adc_start     = rsp.adc_start;
                got.conn_event    = rsp.conn_event;
                got.output_event  = rsp.output_event;
                got.input_event   = rsp.input_event;
                got.sources_now   = rsp.sources_now;
                got.clock_running = rsp.clock_running;
                if (results_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result transfer with nothing expected, sources_now %0h",
                                 $time, got.sources_now);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_field("wait_active", 8'(want.wait_active), 8'(got.wait_active));
                    compare_field("therm_event", 8'(want.therm_event), 8'(got.therm_event));
                    compare_field("adc_start", 8'(want.adc_start), 8'(got.adc_start));
                    compare_field("conn_event", 8'(want.conn_event), 8'(got.conn_event));
                    compare_field("output_event", 8'(want.output_event),
                                  8'(got.output_event));
                    compare_field("input_event", 8'(want.input_event), 8'(got.input_event));
                    compare_field("sources_now", 8'(want.sources_now), 8'(got.sources_now));
                    compare_field("clock_running", 8'(want.clock_running),
                                  8'(got.clock_running));
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                schedule_step(cmd.func, cmd.source_mask, cmd.wait_seconds, want);
                results_due.push_back(want);
            end
            outstanding <= results_due.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import mst_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
    localparam logic [MASK_W-1:0] ALL_SOURCES  = '1;
    localparam logic [SECS_W-1:0] MAX_SECS     = '1;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [TPS_W-1:0] cfg_data;
    logic             quiet;
    int unsigned      mismatches;
    int unsigned      outstanding;

    mst_cmd_if cmd_ch();
    mst_rsp_if rsp_ch();

    multi_source_tick_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    tick_schedule_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 7);
    end

    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [MASK_W-1:0] m,
                            input logic [SECS_W-1:0] s);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.func         <= f;
        cmd_ch.source_mask  <= m;
        cmd_ch.wait_seconds <= s;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // drain all results, then write ticks_per_second while idle
    task automatic drain_and_set_tps(input logic [TPS_W-1:0] tps);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= tps;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_commands(input int n, input int quiet_from, input int quiet_to);
        int unsigned      pick;
        logic [FUNC_W-1:0] f;
        logic [SECS_W-1:0] s;
        for (int i = 0; i < n; i++)
        begin
            quiet = (i >= quiet_from) && (i < quiet_to);
            pick  = $urandom_range(0, 99);
            if (pick < 55)
                f = FUNC_TICK;
            else if (pick < 68)
                f = FUNC_START;
            else if (pick < 76)
                f = FUNC_STOP;
            else if (pick < 86)
                f = FUNC_WAIT;
            else
                f = FUNC_W'($urandom_range(4, 7));
            pick = $urandom_range(0, 99);
            if (pick < 80)
                s = SECS_W'($urandom_range(0, 3));
            else if (pick < 90)
                s = MAX_SECS;
            else
                s = SECS_W'($urandom_range(0, 65535));
            send_cmd(f, MASK_W'($urandom_range(0, 31)), s);
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        quiet                = 1'b0;
        cfg_we              <= 1'b0;
        cfg_data            <= '0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.func         <= FUNC_STATUS;
        cmd_ch.source_mask  <= '0;
        cmd_ch.wait_seconds <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rate of 61 ticks per second
        send_cmd(FUNC_TICK, '0, '0);
        send_cmd(FUNC_STATUS, ALL_SOURCES, MAX_SECS);
        send_cmd(FUNC_SPARE_5, ALL_SOURCES, '0);
        send_cmd(FUNC_SPARE_6, '0, MAX_SECS);
        send_cmd(FUNC_SPARE_7, ALL_SOURCES, MAX_SECS);
        send_cmd(FUNC_STOP, ALL_SOURCES, '0);
        send_cmd(FUNC_START, '0, MAX_SECS);
        send_cmd(FUNC_START, 5'b10101, '0);
        send_cmd(FUNC_TICK, '0, '0);
        send_cmd(FUNC_START, ALL_SOURCES, '0);
        repeat (3) send_cmd(FUNC_TICK, ALL_SOURCES, MAX_SECS);
        send_cmd(FUNC_WAIT, '0, '0);
        send_cmd(FUNC_WAIT, '0, MAX_SECS);
        send_cmd(FUNC_TICK, '0, '0);
        send_cmd(FUNC_STOP, ALL_SOURCES, '0);
        send_cmd(FUNC_TICK, '0, '0);
        send_cmd(FUNC_WAIT, ALL_SOURCES, '0);
        send_cmd(FUNC_TICK, '0, '0);
        send_cmd(FUNC_START, 5'b00001, '0);

        // one tick per second, waits expire quickly
        drain_and_set_tps(8'd1);
        send_cmd(FUNC_WAIT, '0, 16'd1);
        send_cmd(FUNC_TICK, '0, '0);
        send_cmd(FUNC_WAIT, '0, 16'd2);
        repeat (2) send_cmd(FUNC_TICK, '0, '0);
        random_commands(500, 0, 0);

        drain_and_set_tps(8'd255);
        send_cmd(FUNC_WAIT, '0, MAX_SECS);
        random_commands(450, 0, 0);

        // armed wait with an empty countdown
        drain_and_set_tps(8'd0);
        send_cmd(FUNC_WAIT, '0, 16'd5);
        send_cmd(FUNC_TICK, '0, '0);
        random_commands(200, 0, 0);

        drain_and_set_tps(TPS_W'($urandom_range(1, 255)));
        random_commands(800, 250, 550);

        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("multi_source_tick_scheduler verification clean");
        else
            $display("multi_source_tick_scheduler verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("multi_source_tick_scheduler verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mst_pkg.sv
hw/rtl/mst_cmd_if.sv
hw/rtl/mst_rsp_if.sv
hw/rtl/multi_source_tick_scheduler.sv
tb/sv/tick_schedule_checker.sv
tb/sv/tb_top.sv
